// File: rtl/pci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_pkg: shared definitions for the pedal curve interpolator
// Field widths, curve geometry, operation codes and inter-module types.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int DATA_W  = 16;  // sample, point and result width
  localparam int FRAC_W  = 10;  // fractional weight bits of the sample
  localparam int SEG_W   = 6;   // segment select bits of the sample
  localparam int CH_W    = 2;   // channel field width
  localparam int IDX_W   = 7;   // point index field width
  localparam int POINTS  = 65;  // points per curve

  localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic {
    OP_SHAPE = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_IDLE  = 1'b1
  } clr_state_t;

  // access request from the front end to the curve memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: rtl/pedal_curve_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_curve_interpolator: per-channel pedal response shaping
//
// Input words carry an op. A shape word (op 0) maps in_sample through the
// 65-point curve of in_channel: the upper 6 bits choose a segment, the lower
// 10 bits weight the slope between its two points. One out_shaped_value word
// follows each shape word. A write word (op 1) stores in_point_value at
// in_point_index of the channel's curve and yields no output word; indices
// of 65 or more and channels of CHANNELS or more are dropped.
// With curve_enable clear, or an unknown channel, the sample passes through.
// The user writes cfg_curve_enable through the cfg channel only while the
// block is idle; the block itself does not enforce this.
// The memory read registers at acceptance alongside stage 1, then the
// weighting multiply registers in stage 2, then the final add registers in
// the output. One word is accepted per cycle while the curve fill is done
// and the pipeline is not held; the two-port curve memory read and the
// single multiplier allow that rate. A write becomes visible to the very
// next word, since it lands at the acceptance edge. After reset the curves
// are filled with the ramp index * 1024 (top point 65535), one entry a cycle;
// in_ready stays low meanwhile. While a word waits in the output register
// with out_ready low, the whole pipeline holds and in_ready stays low.
// ----------------------------------------------------------------------------
module pedal_curve_interpolator #(
  parameter int CHANNELS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [pci_pkg::CH_W-1:0]            in_channel,
  input  logic [pci_pkg::DATA_W-1:0]          in_sample,
  input  logic [pci_pkg::IDX_W-1:0]           in_point_index,
  input  logic [pci_pkg::DATA_W-1:0]          in_point_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pci_pkg::DATA_W-1:0]          out_shaped_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_curve_enable
);

  localparam int DEPTH  = CHANNELS * pci_pkg::POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [pci_pkg::CH_W:0] CH_LIMIT = (pci_pkg::CH_W + 1)'(CHANNELS);

  logic                         curve_enable_r;
  logic                         busy;
  logic                         adv;
  logic                         accept;
  logic                         ch_ok;
  logic                         idx_ok;
  logic                         bypass;
  logic [ADDR_W-1:0]            ch_base;
  logic [ADDR_W-1:0]            rd_addr_a;
  logic [ADDR_W-1:0]            rd_addr_b;
  logic [ADDR_W-1:0]            wr_addr;
  logic [pci_pkg::DATA_W-1:0]   y1;
  logic [pci_pkg::DATA_W-1:0]   y2;
  pci_pkg::mem_ctl_t            ctl;

  logic                         s1_valid_r;
  logic                         s1_bypass_r;
  logic [pci_pkg::DATA_W-1:0]   s1_sample_r;

  // configuration: always ready; the user writes only while idle (not enforced)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_enable_r <= 1'b0;
    end else if (cfg_valid) begin
      curve_enable_r <= cfg_curve_enable;
    end
  end

  assign in_ready = adv && !busy;
  assign accept   = in_valid && in_ready;

  assign ch_ok  = {1'b0, in_channel} < CH_LIMIT;
  assign idx_ok = in_point_index < pci_pkg::IDX_W'(pci_pkg::POINTS);
  assign bypass = !curve_enable_r || !ch_ok;

  // entry of point zero of the channel: channel * 65 as a shift and an add
  assign ch_base   = (ADDR_W'(in_channel) << pci_pkg::SEG_W) + ADDR_W'(in_channel);
  // the six segment bits top out at 63, so no clamp is needed
  assign rd_addr_a = ch_base + ADDR_W'(in_sample[pci_pkg::DATA_W-1:pci_pkg::FRAC_W]);
  assign rd_addr_b = rd_addr_a + ADDR_W'(1);
  assign wr_addr   = ch_base + ADDR_W'(in_point_index);

  // read only for shaping on a known channel; write only when in range
  assign ctl.rd_en = accept && (in_op == pci_pkg::OP_SHAPE) && !bypass;
  assign ctl.wr_en = accept && (in_op == pci_pkg::OP_WRITE) && ch_ok && idx_ok;

  pci_curve_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (in_point_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (y1),
    .rd_data_b (y2),
    .busy      (busy)
  );

  // stage 1 alongside the memory read; write words leave no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept && (in_op == pci_pkg::OP_SHAPE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bypass_r <= bypass;
      s1_sample_r <= in_sample;
    end
  end

  pci_interp u_interp (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid_r),
    .s1_bypass        (s1_bypass_r),
    .s1_sample        (s1_sample_r),
    .y1               (y1),
    .y2               (y2),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shaped_value (out_shaped_value)
  );

endmodule

// File: rtl/pci_curve_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_curve_mem: curve point store
// One write port, two registered read ports, and a ramp fill after reset.
// ----------------------------------------------------------------------------
module pci_curve_mem #(
  parameter int DEPTH  = 195,
  parameter int ADDR_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pci_pkg::mem_ctl_t           ctl,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [pci_pkg::DATA_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]           rd_addr_a,
  input  logic [ADDR_W-1:0]           rd_addr_b,
  output logic [pci_pkg::DATA_W-1:0]  rd_data_a,
  output logic [pci_pkg::DATA_W-1:0]  rd_data_b,
  output logic                        busy
);

  logic [pci_pkg::DATA_W-1:0] mem [DEPTH];

  pci_pkg::clr_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]           sweep_addr_r, sweep_addr_nxt;
  logic [pci_pkg::IDX_W-1:0]   sweep_idx_r, sweep_idx_nxt;
  logic                        sweep_last;
  logic                        sweep_we;
  logic [pci_pkg::DATA_W-1:0]  ramp_value;
  logic                        we;
  logic [ADDR_W-1:0]           we_addr;
  logic [pci_pkg::DATA_W-1:0]  we_data;

  assign sweep_last = (sweep_addr_r == ADDR_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pci_pkg::CLR_SWEEP: if (sweep_last) state_nxt = pci_pkg::CLR_IDLE;
      pci_pkg::CLR_IDLE:  state_nxt = pci_pkg::CLR_IDLE;
      default:            state_nxt = pci_pkg::CLR_SWEEP;
    endcase
  end

  // outputs of the sweep
  always_comb begin
    sweep_we = 1'b0;
    busy     = 1'b0;
    unique case (state_r)
      pci_pkg::CLR_SWEEP: begin
        sweep_we = 1'b1;
        busy     = 1'b1;
      end
      pci_pkg::CLR_IDLE: begin
        sweep_we = 1'b0;
        busy     = 1'b0;
      end
      default: begin
        sweep_we = 1'b0;
        busy     = 1'b1;
      end
    endcase
  end

  always_comb begin
    sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
    if (sweep_idx_r == pci_pkg::IDX_W'(pci_pkg::POINTS - 1)) begin
      sweep_idx_nxt = '0;
    end else begin
      sweep_idx_nxt = sweep_idx_r + pci_pkg::IDX_W'(1);
    end
  end

  // ramp of index times 1024, top point clamped to full scale
  always_comb begin
    if (sweep_idx_r[pci_pkg::SEG_W]) begin
      ramp_value = pci_pkg::FULL_SCALE;
    end else begin
      ramp_value = {sweep_idx_r[pci_pkg::SEG_W-1:0], pci_pkg::FRAC_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pci_pkg::CLR_SWEEP;
      sweep_addr_r <= '0;
      sweep_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (sweep_we) begin
        sweep_addr_r <= sweep_addr_nxt;
        sweep_idx_r  <= sweep_idx_nxt;
      end
    end
  end

  assign we      = sweep_we || ctl.wr_en;
  assign we_addr = sweep_we ? sweep_addr_r : wr_addr;
  assign we_data = sweep_we ? ramp_value : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[we_addr] <= we_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: rtl/pci_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_interp: interpolation datapath
// Weight the segment slope, add it to the first point, or pass bypass samples.
// ----------------------------------------------------------------------------
module pci_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  logic                        s1_bypass,
  input  logic [pci_pkg::DATA_W-1:0]  s1_sample,
  input  logic [pci_pkg::DATA_W-1:0]  y1,
  input  logic [pci_pkg::DATA_W-1:0]  y2,
  output logic                        adv,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pci_pkg::DATA_W-1:0]  out_shaped_value
);

  localparam int PROD_W = pci_pkg::DATA_W + pci_pkg::FRAC_W + 2;

  logic signed [pci_pkg::DATA_W:0]    diff;
  logic signed [pci_pkg::FRAC_W:0]    weight;
  logic signed [PROD_W-1:0]           prod;
  logic signed [PROD_W-1:0]           prod_sh;

  logic                               s2_valid_r;
  logic [pci_pkg::DATA_W-1:0]         s2_base_r;
  logic [pci_pkg::DATA_W-1:0]         s2_q_r;
  logic                               out_valid_r;
  logic [pci_pkg::DATA_W-1:0]         out_value_r;

  assign adv = !out_valid_r || out_ready;

  assign diff    = signed'({1'b0, y2}) - signed'({1'b0, y1});
  assign weight  = signed'({1'b0, s1_sample[pci_pkg::FRAC_W-1:0]});
  assign prod    = diff * weight;
  // arithmetic shift floors towards minus infinity
  assign prod_sh = prod >>> pci_pkg::FRAC_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_bypass) begin
        s2_base_r <= s1_sample;
        s2_q_r    <= '0;
      end else begin
        s2_base_r <= y1;
        s2_q_r    <= prod_sh[pci_pkg::DATA_W-1:0];
      end
      out_value_r <= s2_base_r + s2_q_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shaped_value = out_value_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pedal_curve_interpolator
// Drives shape and write words with random gaps on all channels, keeps its
// own copy of the three response curves and the enable bit, predicts every
// shaped word the plan does not give and compares each with the output in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHANNELS       = 3;
  localparam int PLAN_ROWS      = 23;
  localparam int PHASES         = 6;
  localparam int WORDS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES  = 8;       // pipeline is 3 deep; leave slack
  localparam int CYCLE_LIMIT    = 300000;  // far beyond the slowest clean run
  localparam int REPORT_CAP     = 50;

  // one input word as the bench sees it
  typedef struct {
    pci_pkg::op_t               op;
    logic [pci_pkg::CH_W-1:0]   channel;
    logic [pci_pkg::DATA_W-1:0] sample;
    logic [pci_pkg::IDX_W-1:0]  index;
    logic [pci_pkg::DATA_W-1:0] value;
  } pedal_word_t;

  // one row of the directed plan; want is used only where typed is set
  typedef struct packed {
    pci_pkg::op_t               op;
    logic [pci_pkg::CH_W-1:0]   channel;
    logic [pci_pkg::DATA_W-1:0] sample;
    logic [pci_pkg::IDX_W-1:0]  index;
    logic [pci_pkg::DATA_W-1:0] value;
    logic                       enable;
    logic                       typed;
    logic [pci_pkg::DATA_W-1:0] want;
  } plan_row_t;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic                       in_op            = 1'b0;
  logic [pci_pkg::CH_W-1:0]   in_channel       = '0;
  logic [pci_pkg::DATA_W-1:0] in_sample        = '0;
  logic [pci_pkg::IDX_W-1:0]  in_point_index   = '0;
  logic [pci_pkg::DATA_W-1:0] in_point_value   = '0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic [pci_pkg::DATA_W-1:0] out_shaped_value;
  logic                       cfg_valid        = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_curve_enable = 1'b0;

  // bench copy of the block's state
  logic [pci_pkg::DATA_W-1:0] curve_pts [CHANNELS][pci_pkg::POINTS];
  logic                       curve_on;

  logic [pci_pkg::DATA_W-1:0] shaped_due [$];   // shaped words still owed by the block
  int                errors = 0;
  int                cycles = 0;
  int                send_idle_pct = 38;
  int                recv_idle_pct = 50;

  // Directed plan. Rows that can be read straight off the curve carry their
  // answer; the rest go through the predictor.
  plan_row_t plan [PLAN_ROWS] = '{
    // curve off: samples pass straight through
    '{pci_pkg::OP_SHAPE, 2'd0, 16'h0000, 7'd0,   16'h0000, 1'b0, 1'b1, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd0, 16'hFFFF, 7'd0,   16'h0000, 1'b0, 1'b1, 16'hFFFF},
    '{pci_pkg::OP_SHAPE, 2'd2, 16'h1234, 7'd0,   16'h0000, 1'b0, 1'b1, 16'h1234},
    // a write lands even while the curve is off
    '{pci_pkg::OP_WRITE, 2'd0, 16'h0000, 7'd5,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
    // curve on over the reset ramp: identity except in the top segment
    '{pci_pkg::OP_SHAPE, 2'd0, 16'h0000, 7'd0,   16'h0000, 1'b1, 1'b1, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd1, 16'hFFFF, 7'd0,   16'h0000, 1'b1, 1'b1, 16'hFFFE},
    '{pci_pkg::OP_SHAPE, 2'd2, 16'h8000, 7'd0,   16'h0000, 1'b1, 1'b1, 16'h8000},
    // channel beyond the curves passes through
    '{pci_pkg::OP_SHAPE, 2'd3, 16'hABCD, 7'd0,   16'h0000, 1'b1, 1'b1, 16'hABCD},
    // either side of the raised point: steep rise, then steep fall
    '{pci_pkg::OP_SHAPE, 2'd0, 16'h1400, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd0, 16'h13FF, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd0, 16'h17FF, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    // full-scale drop across the clamped top segment, last point written
    '{pci_pkg::OP_WRITE, 2'd1, 16'h0000, 7'd64,  16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_WRITE, 2'd1, 16'h0000, 7'd63,  16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd1, 16'hFFFF, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd1, 16'hFC00, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd1, 16'hFE01, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    // writes that must be dropped: index past the curve, unknown channel
    '{pci_pkg::OP_WRITE, 2'd2, 16'h0000, 7'd65,  16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_WRITE, 2'd2, 16'h0000, 7'd127, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_WRITE, 2'd3, 16'h0000, 7'd0,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd2, 16'hFFFF, 7'd0,   16'h0000, 1'b1, 1'b1, 16'hFFFE},
    // write then read back to back
    '{pci_pkg::OP_WRITE, 2'd2, 16'h0000, 7'd0,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd2, 16'h0000, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000},
    '{pci_pkg::OP_SHAPE, 2'd2, 16'h03FF, 7'd0,   16'h0000, 1'b1, 1'b0, 16'h0000}
  };

  pedal_curve_interpolator #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .in_point_index   (in_point_index),
    .in_point_value   (in_point_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shaped_value (out_shaped_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_curve_enable (cfg_curve_enable)
  );

  always #2 clk = ~clk;

  // Shape one sample through the bench curves. The slope term is floored,
  // which an arithmetic shift of a signed product gives directly.
  function automatic logic [pci_pkg::DATA_W-1:0] shaped_from_curve(
    input logic [pci_pkg::CH_W-1:0] ch, input logic [pci_pkg::DATA_W-1:0] s);
    int seg;
    int y_lo;
    int y_hi;
    int slope;
    if (!curve_on || ch >= CHANNELS)
      return s;
    seg = int'(s[pci_pkg::DATA_W-1:pci_pkg::FRAC_W]);
    if (seg > pci_pkg::POINTS - 2)
      seg = pci_pkg::POINTS - 2;
    y_lo  = int'(curve_pts[ch][seg]);
    y_hi  = int'(curve_pts[ch][seg + 1]);
    slope = (y_hi - y_lo) * int'(s[pci_pkg::FRAC_W-1:0]);
    return pci_pkg::DATA_W'(y_lo + (slope >>> pci_pkg::FRAC_W));
  endfunction

  // Random word: mostly in-range channels and indices, with the segment
  // boundaries, the clamped top segment and the rails drawn often.
  function automatic pedal_word_t random_word();
    pedal_word_t w;
    w.op = ($urandom_range(99) < 30) ? pci_pkg::OP_WRITE : pci_pkg::OP_SHAPE;
    if ($urandom_range(9) == 0)
      w.channel = pci_pkg::CH_W'($urandom_range(3));
    else
      w.channel = pci_pkg::CH_W'($urandom_range(CHANNELS - 1));
    case ($urandom_range(7))
      0:       w.sample = '0;
      1:       w.sample = pci_pkg::FULL_SCALE;
      2:       w.sample = {6'h3F, 10'($urandom)};
      3:       w.sample = {6'($urandom), 10'h3FF};
      4:       w.sample = {6'($urandom), 10'h000};
      default: w.sample = pci_pkg::DATA_W'($urandom);
    endcase
    if ($urandom_range(9) == 0)
      w.index = pci_pkg::IDX_W'($urandom_range(127, pci_pkg::POINTS));
    else
      w.index = pci_pkg::IDX_W'($urandom_range(pci_pkg::POINTS - 1));
    case ($urandom_range(5))
      0:       w.value = '0;
      1:       w.value = pci_pkg::FULL_SCALE;
      default: w.value = pci_pkg::DATA_W'($urandom);
    endcase
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    if (errors < REPORT_CAP)
      $display("mismatch, cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Offer one word, idling first at the sender's rate. On acceptance,
  // advance the bench state and queue the shaped word owed, if any.
  task automatic send_word(input pedal_word_t w, input logic typed,
                           input logic [pci_pkg::DATA_W-1:0] want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= w.op;
    in_channel     <= w.channel;
    in_sample      <= w.sample;
    in_point_index <= w.index;
    in_point_value <= w.value;
    do @(posedge clk); while (!in_ready);
    if (w.op == pci_pkg::OP_WRITE) begin
      if (w.channel < CHANNELS && w.index < pci_pkg::POINTS)
        curve_pts[w.channel][w.index] = w.value;
    end else begin
      shaped_due.push_back(typed ? want : shaped_from_curve(w.channel, w.sample));
    end
  endtask

  // Drop valid and wait until every owed word is out; write words leave no
  // trace at the output, so also let the pipeline empty before going on.
  task automatic settle();
    in_valid <= 1'b0;
    while (shaped_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_curve_enable(input logic on);
    settle();
    cfg_valid        <= 1'b1;
    cfg_curve_enable <= on;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    curve_on = on;
  endtask

  // Receiver: stall at random and check each output word against the
  // oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (shaped_due.size() == 0)
        flag_mismatch($sformatf("shaped_value %h with none owed", out_shaped_value));
      else if (out_shaped_value !== shaped_due[0])
        flag_mismatch($sformatf("shaped_value %h, want %h",
                                out_shaped_value, shaped_due[0]));
      if (shaped_due.size() != 0)
        void'(shaped_due.pop_front());
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop should the block hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    pedal_word_t w;
    int          p;
    for (int c = 0; c < CHANNELS; c++)
      for (int i = 0; i < pci_pkg::POINTS; i++)
        curve_pts[c][i] = (i * 1024 > 65535) ? pci_pkg::FULL_SCALE
                                             : pci_pkg::DATA_W'(i * 1024);
    curve_on = 1'b0;

    // hold reset, then release; the block fills its curves with the ramp on its own
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan, changing the enable only where a row needs it
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].enable != curve_on)
        set_curve_enable(plan[r].enable);
      w.op      = plan[r].op;
      w.channel = plan[r].channel;
      w.sample  = plan[r].sample;
      w.index   = plan[r].index;
      w.value   = plan[r].value;
      send_word(w, plan[r].typed, plan[r].want);
    end

    // random phases: receiver-heavy idling, sender-heavy, then flat out
    for (p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_curve_enable(p != 1 && p != 4);
      repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
    end

    settle();
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
